// ===== hdl/mtg_pkg.sv =====
// Shared constants, tap bundle and word functions of the MT19937 generator.
package mtg_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned TblN  = 624;
  localparam int unsigned TblM  = 397;
  localparam int unsigned IdxW  = 10;

  localparam int unsigned KeyWordsMaxDefault = 16;

  localparam logic [1:0] ACT_SEED = 2'd0;
  localparam logic [1:0] ACT_KEY  = 2'd1;
  localparam logic [1:0] ACT_DRAW = 2'd2;

  localparam logic [WordW-1:0] K_LINEAR    = 32'd1812433253;
  localparam logic [WordW-1:0] K_PASS1     = 32'd1664525;
  localparam logic [WordW-1:0] K_PASS2     = 32'd1566083941;
  localparam logic [WordW-1:0] ARRAY_SEED  = 32'd19650218;
  localparam logic [WordW-1:0] DEFAULT_SEED = 32'd5489;
  localparam logic [WordW-1:0] HIGH_BIT    = 32'h8000_0000;
  localparam logic [WordW-1:0] LOW_BITS    = 32'h7fff_ffff;
  localparam logic [WordW-1:0] TWIST_XOR   = 32'h9908_b0df;
  localparam logic [WordW-1:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [WordW-1:0] TEMPER_C    = 32'hefc6_0000;

  // Fixed taps of the ring: head word, its successor and the word M ahead.
  typedef struct packed {
    logic [WordW-1:0] head;
    logic [WordW-1:0] next;
    logic [WordW-1:0] mid;
  } ring_taps_t;

  function automatic logic [WordW-1:0] fold30(input logic [WordW-1:0] v);
    return v ^ (v >> 30);
  endfunction

  function automatic logic [WordW-1:0] twist_word(input ring_taps_t t);
    logic [WordW-1:0] y;
    y = (t.head & HIGH_BIT) | (t.next & LOW_BITS);
    return t.mid ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
  endfunction

  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] v);
    logic [WordW-1:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hdl/mtg_cell.sv =====
// One word cell of the state ring: loads its neighbor's word when the ring advances.
module mtg_cell (
  input  logic                       clk_i,
  input  logic                       shift_en_i,
  input  logic [mtg_pkg::WordW-1:0]  d_i,
  output logic [mtg_pkg::WordW-1:0]  q_o
);
  import mtg_pkg::*;

  logic [WordW-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

// ===== hdl/mtg_ring.sv =====
// Ring of state cells: the tail takes a new word, every cell passes its word toward the head.
module mtg_ring (
  input  logic                       clk_i,
  input  logic                       shift_en_i,
  input  logic [mtg_pkg::WordW-1:0]  tail_i,
  output mtg_pkg::ring_taps_t        taps_o
);
  import mtg_pkg::*;

  logic [WordW-1:0] cell_q [TblN];

  for (genvar k = 0; k < TblN; k++) begin : g_cell
    logic [WordW-1:0] cell_d;
    if (k == TblN - 1) begin : g_tail
      assign cell_d = tail_i;
    end else begin : g_body
      assign cell_d = cell_q[k+1];
    end
    mtg_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en_i),
      .d_i        (cell_d),
      .q_o        (cell_q[k])
    );
  end

  assign taps_o.head = cell_q[0];
  assign taps_o.next = cell_q[1];
  assign taps_o.mid  = cell_q[TblM];

endmodule

// ===== hdl/mersenne_twister_generator.sv =====
// Top level of the MT19937 generator: sequencer, key store, multiplier and output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------------
//   in      | sink      | in_valid_i / in_ready_o  | action_i, seed_value_i, key_word_i,
//           |           |                          | key_last_i
//   out     | source    | out_valid_o / out_ready_i| random_word_o
//
// A draw transaction is handled on the fly: the ring twists its head word and the
// tempered word lands in the output register, so draws stream one per cycle while the
// output is drained. A seed transaction occupies the ring while it fills the table, one
// word per cycle through the multiplier. The final key word costs a linear fill, the two
// array passes with a copy step at each table wrap, and a rotation that brings the forced
// word 0 back to the head. A draw before any seeding holds off while the ring fills from
// the default seed. Reset clears the sequencer and the output valid; the ring and the key
// store hold no reset value. A stalled output only blocks input while its word waits.
module mersenne_twister_generator #(
  parameter int unsigned KEY_WORDS_MAX = mtg_pkg::KeyWordsMaxDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [mtg_pkg::WordW-1:0]  seed_value_i,
  input  logic [mtg_pkg::WordW-1:0]  key_word_i,
  input  logic                       key_last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mtg_pkg::WordW-1:0]  random_word_o
);
  import mtg_pkg::*;

  localparam int unsigned CntW = $clog2(KEY_WORDS_MAX + 1);
  localparam int unsigned AddrW = (KEY_WORDS_MAX > 1) ? $clog2(KEY_WORDS_MAX) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINEAR,
    ST_PASS1,
    ST_PASS2,
    ST_ALIGN
  } state_e;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  pos_q, pos_d, pos_inc;
  logic [IdxW-1:0]  steps_q, steps_d;
  logic [AddrW-1:0] key_rd_idx_q, key_rd_idx_d;
  logic [CntW-1:0]  key_len_q, key_len_d;
  logic [CntW-1:0]  key_count_q, key_count_d, key_count_inc;
  logic [CntW:0]    key_rd_next;
  logic             seeded_q, seeded_d;
  logic             keyed_q, keyed_d;
  logic             first_q, first_d;
  logic             forced_q, forced_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] random_word_q, random_word_d;

  logic [WordW-1:0] prev_q, prev_d;
  logic [WordW-1:0] key_rd_q;
  logic [WordW-1:0] key_mem_q [KEY_WORDS_MAX];
  logic             key_we;

  logic             in_acc;
  logic             shift_en;
  logic [WordW-1:0] tail;
  logic [WordW-1:0] twisted;
  logic [WordW-1:0] mul_k;
  logic [WordW-1:0] prod;
  ring_taps_t       taps;

  mtg_ring u_ring (
    .clk_i      (clk_i),
    .shift_en_i (shift_en),
    .tail_i     (tail),
    .taps_o     (taps)
  );

  // Hold off input while the ring is busy or a finished word still waits; an unseeded
  // draw is held until the default fill has run.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i) &&
                      (seeded_q || (action_i != ACT_DRAW));
  assign in_acc     = in_valid_i && in_ready_o;

  assign twisted = twist_word(taps);

  // One shared 32x32 multiplier, low half only; the constant follows the phase.
  always_comb begin
    case (state_q)
      ST_PASS1: mul_k = K_PASS1;
      ST_PASS2: mul_k = K_PASS2;
      default:  mul_k = K_LINEAR;
    endcase
  end
  assign prod = fold30(prev_q) * mul_k;

  assign pos_inc       = (pos_q == IdxW'(TblN - 1)) ? '0 : pos_q + 1'b1;
  assign key_count_inc = (key_count_q < CntW'(KEY_WORDS_MAX)) ? key_count_q + 1'b1
                                                              : key_count_q;
  assign key_rd_next   = (CntW+1)'(key_rd_idx_q) + 1'b1;

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    steps_d       = steps_q;
    key_rd_idx_d  = key_rd_idx_q;
    key_len_d     = key_len_q;
    key_count_d   = key_count_q;
    seeded_d      = seeded_q;
    keyed_d       = keyed_q;
    first_d       = first_q;
    forced_d      = forced_q;
    prev_d        = prev_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    random_word_d = random_word_q;
    key_we        = 1'b0;
    shift_en      = 1'b0;
    tail          = taps.head;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_i)
            ACT_SEED: begin
              state_d  = ST_LINEAR;
              pos_d    = '0;
              prev_d   = seed_value_i;
              seeded_d = 1'b1;
              keyed_d  = 1'b0;
            end
            ACT_KEY: begin
              key_we      = key_count_q < CntW'(KEY_WORDS_MAX);
              key_count_d = key_count_inc;
              if (key_last_i) begin
                // Start array seeding over the words stored so far.
                key_len_d   = key_count_inc;
                key_count_d = '0;
                state_d     = ST_LINEAR;
                pos_d       = '0;
                prev_d      = ARRAY_SEED;
                seeded_d    = 1'b1;
                keyed_d     = 1'b1;
              end
            end
            ACT_DRAW: begin
              // Twist the head word, advance the ring, present the tempered word.
              shift_en      = 1'b1;
              tail          = twisted;
              pos_d         = pos_inc;
              out_valid_d   = 1'b1;
              random_word_d = temper(twisted);
            end
            default: ;
          endcase
        end else if (in_valid_i && (action_i == ACT_DRAW) && !seeded_q) begin
          state_d  = ST_LINEAR;
          pos_d    = '0;
          prev_d   = DEFAULT_SEED;
          seeded_d = 1'b1;
          keyed_d  = 1'b0;
        end
      end

      ST_LINEAR: begin
        // Fill word pos; word 0 is the seed itself.
        shift_en     = 1'b1;
        tail         = (pos_q == '0) ? prev_q : prod + WordW'(pos_q);
        prev_d       = tail;
        pos_d        = pos_inc;
        key_rd_idx_d = '0;
        if (pos_q == IdxW'(TblN - 1)) begin
          if (keyed_q) begin
            state_d = ST_PASS1;
            first_d = 1'b1;
            steps_d = (IdxW'(key_len_q) > IdxW'(TblN)) ? IdxW'(key_len_q) : IdxW'(TblN);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_PASS1: begin
        shift_en = 1'b1;
        pos_d    = pos_inc;
        if (first_q) begin
          // Move word 0 out of the head unchanged; it is the first predecessor.
          prev_d  = taps.head;
          first_d = 1'b0;
        end else if (pos_q == '0) begin
          // Table wrap: word 0 takes a copy of word 623.
          tail = prev_q;
        end else begin
          // Key memory holds each key word already offset by its index.
          tail         = (taps.head ^ prod) + key_rd_q;
          prev_d       = tail;
          key_rd_idx_d = (key_rd_next == (CntW+1)'(key_len_q)) ? '0
                                                                : AddrW'(key_rd_next);
          steps_d      = steps_q - 1'b1;
          if (steps_q == IdxW'(1)) begin
            state_d = ST_PASS2;
            steps_d = IdxW'(TblN - 1);
          end
        end
      end

      ST_PASS2: begin
        shift_en = 1'b1;
        pos_d    = pos_inc;
        if (pos_q == '0) begin
          tail = prev_q;
        end else begin
          tail    = (taps.head ^ prod) - WordW'(pos_q);
          prev_d  = tail;
          steps_d = steps_q - 1'b1;
          if (steps_q == IdxW'(1)) begin
            state_d  = ST_ALIGN;
            forced_d = 1'b0;
          end
        end
      end

      ST_ALIGN: begin
        // Rotate until word 0 is forced and back at the head.
        shift_en = 1'b1;
        pos_d    = pos_inc;
        if (pos_q == '0) begin
          tail     = HIGH_BIT;
          forced_d = 1'b1;
        end
        if ((pos_q == IdxW'(TblN - 1)) && forced_q) begin
          state_d = ST_IDLE;
          keyed_d = 1'b0;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      steps_q       <= '0;
      key_rd_idx_q  <= '0;
      key_len_q     <= '0;
      key_count_q   <= '0;
      seeded_q      <= 1'b0;
      keyed_q       <= 1'b0;
      first_q       <= 1'b0;
      forced_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      random_word_q <= '0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      steps_q       <= steps_d;
      key_rd_idx_q  <= key_rd_idx_d;
      key_len_q     <= key_len_d;
      key_count_q   <= key_count_d;
      seeded_q      <= seeded_d;
      keyed_q       <= keyed_d;
      first_q       <= first_d;
      forced_q      <= forced_d;
      out_valid_q   <= out_valid_d;
      random_word_q <= random_word_d;
    end
  end

  // Predecessor word and key memory; the read port runs one index ahead.
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    if (key_we) begin
      key_mem_q[key_count_q[AddrW-1:0]] <= key_word_i + WordW'(key_count_q);
    end
    key_rd_q <= key_mem_q[key_rd_idx_d];
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = random_word_q;

endmodule

// ===== tb/mersenne_twister_generator_tb.sv =====
// Self-checking testbench of the MT19937 generator: seeding, key loading and streamed draws.
module mersenne_twister_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Algorithm constants kept apart from the package so the RTL copies get checked too.
  localparam int unsigned RING_N   = 624;
  localparam int unsigned RING_M   = 397;
  localparam int unsigned UNSEEDED = RING_N + 1;
  localparam int unsigned KEY_CAP  = 16;

  localparam logic [31:0] MUL_LINEAR     = 32'd1812433253;
  localparam logic [31:0] MUL_PASS1      = 32'd1664525;
  localparam logic [31:0] MUL_PASS2      = 32'd1566083941;
  localparam logic [31:0] KEY_ARRAY_SEED = 32'd19650218;
  localparam logic [31:0] FALLBACK_SEED  = 32'd5489;
  localparam logic [31:0] TOP_BIT        = 32'h8000_0000;
  localparam logic [31:0] LOW_31_BITS    = 32'h7fff_ffff;
  localparam logic [31:0] TWIST_TERM     = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_MASK_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_MASK_C  = 32'hefc6_0000;

  // The one action code the block has no meaning for.
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam int unsigned ITEM_TARGET   = 1650;
  localparam int unsigned IDLE_PCT      = 38;
  // Longest silent item is the final key word, which waits out the array seeding.
  localparam int unsigned SETTLE_CYCLES = 4000;
  localparam int unsigned DRAIN_CYCLES  = 20000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] seed_value;
    logic [31:0] key_word;
    logic        key_last;
    bit          drain_first;  // hold this transaction until every word is back
  } gen_request_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i     = mtg_pkg::ACT_DRAW;
  logic [31:0] seed_value_i = '0;
  logic [31:0] key_word_i   = '0;
  logic        key_last_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [31:0] random_word_o;

  gen_request_t request_queue[$];
  logic [31:0]  word_fifo[$];
  bit           failed = 1'b0;
  int unsigned  cycle_no = 0;
  int unsigned  live_items = 0;
  logic         steady;

  // Shadow copy of the generator state.
  logic [31:0] mt_ring [RING_N];
  int unsigned mt_pos = UNSEEDED;
  logic [31:0] key_buf [KEY_CAP];
  int unsigned key_fill = 0;

  mersenne_twister_generator #(
    .KEY_WORDS_MAX(KEY_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .seed_value_i (seed_value_i),
    .key_word_i   (key_word_i),
    .key_last_i   (key_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_o(random_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Suppress idling on both sides during a recurring steady window.
  assign steady = (cycle_no % 30000) >= 8000 && (cycle_no % 30000) < 14000;

  // ---------------------------------------------------------------------------------------
  // Predictor of the generator
  // ---------------------------------------------------------------------------------------

  function automatic logic [31:0] spread30(input logic [31:0] v);
    return v ^ (v >> 30);
  endfunction

  // Fill the ring from one word by the linear recurrence.
  function automatic void fill_linear(input logic [31:0] s);
    mt_ring[0] = s;
    for (int unsigned n = 1; n < RING_N; n++)
      mt_ring[n] = MUL_LINEAR * spread30(mt_ring[n - 1]) + 32'(n);
    mt_pos = RING_N;
  endfunction

  // Two-pass seeding over the first len key words; word 0 is forced to the top bit.
  function automatic void fill_from_key(input int unsigned len);
    int unsigned i;
    int unsigned j;
    int unsigned k;
    fill_linear(KEY_ARRAY_SEED);
    i = 1;
    j = 0;
    for (k = (RING_N > len) ? RING_N : len; k != 0; k--) begin
      mt_ring[i] = (mt_ring[i] ^ (spread30(mt_ring[i - 1]) * MUL_PASS1)) + key_buf[j] + 32'(j);
      i++;
      j++;
      if (i >= RING_N) begin
        mt_ring[0] = mt_ring[RING_N - 1];
        i = 1;
      end
      if (j >= len) j = 0;
    end
    for (k = RING_N - 1; k != 0; k--) begin
      mt_ring[i] = (mt_ring[i] ^ (spread30(mt_ring[i - 1]) * MUL_PASS2)) - 32'(i);
      i++;
      if (i >= RING_N) begin
        mt_ring[0] = mt_ring[RING_N - 1];
        i = 1;
      end
    end
    mt_ring[0] = TOP_BIT;
  endfunction

  // Regenerate all words in place; later words see the already updated early ones.
  function automatic void regenerate_ring();
    logic [31:0] y;
    for (int unsigned n = 0; n < RING_N; n++) begin
      y = (mt_ring[n] & TOP_BIT) | (mt_ring[(n + 1) % RING_N] & LOW_31_BITS);
      mt_ring[n] = mt_ring[(n + RING_M) % RING_N] ^ (y >> 1) ^ (y[0] ? TWIST_TERM : 32'h0);
    end
    mt_pos = 0;
  endfunction

  function automatic logic [31:0] tempered(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & TEMPER_MASK_B);
    y = y ^ ((y << 15) & TEMPER_MASK_C);
    return y ^ (y >> 18);
  endfunction

  // Advance the shadow state by one transaction; return 1 with the word a draw yields.
  function automatic bit predict_word(input logic [1:0] act, input logic [31:0] seed,
                                      input logic [31:0] word, input logic last,
                                      output logic [31:0] drawn);
    drawn = '0;
    case (act)
      mtg_pkg::ACT_SEED: begin
        fill_linear(seed);
        return 1'b0;
      end
      mtg_pkg::ACT_KEY: begin
        // Drop key words beyond capacity; a dropped last word still seeds.
        if (key_fill < KEY_CAP) begin
          key_buf[key_fill] = word;
          key_fill++;
        end
        if (last) begin
          fill_from_key(key_fill);
          key_fill = 0;
        end
        return 1'b0;
      end
      mtg_pkg::ACT_DRAW: begin
        if (mt_pos >= RING_N) begin
          if (mt_pos != RING_N) fill_linear(FALLBACK_SEED);
          regenerate_ring();
        end
        drawn = tempered(mt_ring[mt_pos]);
        mt_pos++;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: feed the input channel from request_queue and toggle the output ready
  // ---------------------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    gen_request_t req;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
      cycle_no    <= 0;
    end else begin
      cycle_no    <= cycle_no + 1;
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
      // Change the payload only when no transaction is pending on the channel.
      if (!in_valid_i || in_ready_o) begin
        if (request_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT) &&
            !(request_queue[0].drain_first && (in_valid_i || word_fifo.size() != 0))) begin
          req = request_queue.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= req.action;
          seed_value_i <= req.seed_value;
          key_word_i   <= req.key_word;
          key_last_i   <= req.key_last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: predict on accepted requests, compare accepted words
  // ---------------------------------------------------------------------------------------

  always @(posedge clk_i) begin
    logic [31:0] want;
    logic [31:0] drawn;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (predict_word(action_i, seed_value_i, key_word_i, key_last_i, drawn))
          word_fifo.push_back(drawn);
      end
      if (out_valid_o && out_ready_i) begin
        if (word_fifo.size() == 0) begin
          $display("%0t: random_word_o expected none actual %h", $time, random_word_o);
          failed = 1'b1;
        end else begin
          want = word_fifo.pop_front();
          if (random_word_o !== want) begin
            $display("%0t: random_word_o expected %h actual %h", $time, want, random_word_o);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  task automatic add_request(input logic [1:0] act, input logic [31:0] seed,
                             input logic [31:0] word, input logic last, input bit drain);
    gen_request_t req;
    req.action      = act;
    req.seed_value  = seed;
    req.key_word    = word;
    req.key_last    = last;
    req.drain_first = drain;
    request_queue.push_back(req);
    if (act != ACT_IGNORED) live_items++;
  endtask

  // Queue n draws with random don't-care fields; optionally hold the first until drained.
  task automatic add_draws(input int unsigned n, input bit drain);
    for (int unsigned d = 0; d < n; d++)
      add_request(mtg_pkg::ACT_DRAW, $urandom, $urandom, 1'($urandom), drain && d == 0);
  endtask

  // Pick a word, leaning on the extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned burst_len(input bit stretch);
    if (stretch || $urandom_range(14) == 0) return $urandom_range(300, 700);
    return $urandom_range(1, 40);
  endfunction

  initial begin
    int unsigned pick;
    int unsigned len;
    bit          opening;

    // Draw before any seeding: the block falls back to the default seed.
    add_draws(2, 1'b0);
    add_request(ACT_IGNORED, $urandom, $urandom, 1'b1, 1'b0);
    add_request(mtg_pkg::ACT_SEED, 32'h0000_0000, $urandom, 1'b0, 1'b0);
    add_draws(1, 1'b0);
    add_request(mtg_pkg::ACT_KEY, $urandom, 32'h0000_0000, 1'b0, 1'b0);
    add_request(mtg_pkg::ACT_KEY, $urandom, 32'hffff_ffff, 1'b0, 1'b0);
    // Seed in the middle of key loading: loaded key words are kept.
    add_request(mtg_pkg::ACT_SEED, 32'hffff_ffff, $urandom, 1'b1, 1'b0);
    add_draws(1, 1'b0);
    // Fill the key store to capacity, then end with a word that gets dropped.
    for (int unsigned w = 0; w < KEY_CAP - 2; w++)
      add_request(mtg_pkg::ACT_KEY, $urandom, $urandom, 1'b0, 1'b0);
    add_request(mtg_pkg::ACT_KEY, $urandom, $urandom, 1'b1, 1'b0);
    add_draws(1, 1'b0);

    // Random sequences; the first one is a seed and a long draw run.
    opening = 1'b1;
    while (live_items < ITEM_TARGET) begin
      pick = opening ? 0 : $urandom_range(99);
      if (pick < 35) begin
        add_request(mtg_pkg::ACT_SEED, pick_word(), $urandom, 1'($urandom), opening);
        add_draws(burst_len(opening), 1'b0);
      end else if (pick < 60) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(KEY_CAP + 1, KEY_CAP + 4)
                                       : $urandom_range(1, KEY_CAP);
        for (int unsigned w = 1; w <= len; w++)
          add_request(mtg_pkg::ACT_KEY, $urandom, pick_word(), w == len, 1'b0);
        add_draws(burst_len(1'b0), 1'b0);
      end else if (pick < 85) begin
        add_draws(burst_len(1'b0), 1'b0);
      end else if (pick < 95) begin
        // Noise: unknown actions, stray key words, seeds that cut into key loading.
        case ($urandom_range(2))
          0:       repeat ($urandom_range(1, 3))
                     add_request(ACT_IGNORED, $urandom, $urandom, 1'($urandom), 1'b0);
          1:       add_request(mtg_pkg::ACT_KEY, $urandom, pick_word(), 1'b0, 1'b0);
          default: add_request(mtg_pkg::ACT_SEED, pick_word(), $urandom, 1'($urandom), 1'b0);
        endcase
      end else begin
        add_draws(burst_len(1'b0), 1'b1);
      end
      opening = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last transaction to go in, then for the words to come back.
    while (request_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    for (int unsigned c = 0; c < DRAIN_CYCLES && word_fifo.size() != 0; c++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (word_fifo.size() != 0) begin
      $display("%0t: random_word_o expected %h actual none (%0d words missing)", $time,
               word_fifo[0], word_fifo.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mtg_pkg.sv
hdl/mtg_cell.sv
hdl/mtg_ring.sv
hdl/mersenne_twister_generator.sv
tb/mersenne_twister_generator_tb.sv
